// ===== design/rlw_pkg.sv =====
package rlw_pkg;

    // Fixed-point format of coordinates and k4 (signed Q4.14); aspect terms are unsigned Q3.14.
    localparam int FRAC = 14;
    localparam longint ONE = 64'sd1 << FRAC;
    localparam longint HALF = 64'sd1 << (FRAC - 1);

    // Internal clamps on the squared radius, its square and the warped offsets.
    localparam longint R2_CAP = (64'sd1 <<< 31) - 1;
    localparam longint R4_CAP = (64'sd1 <<< 45) - 1;
    localparam longint U_CAP = (64'sd1 <<< 38) - 1;
    localparam longint OUT_MAX = 64'sd131071;
    localparam longint OUT_MIN = -64'sd131072;

    // Configuration register indexes.
    localparam logic [2:0] REG_ENABLE = 3'd0;
    localparam logic [2:0] REG_PERSP = 3'd1;
    localparam logic [2:0] REG_K4 = 3'd2;
    localparam logic [2:0] REG_ASPECT = 3'd3;
    localparam logic [2:0] REG_INV_ASPECT = 3'd4;

    typedef struct packed {
        logic enable;
        logic persp;
        logic signed [17:0] k4;
        logic [16:0] aspect;
        logic [16:0] inv_aspect;
    } cfg_t;

    // Drops the fraction bits, rounding to nearest with ties away from zero.
    function automatic logic signed [63:0] rnd_frac(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] q;
        mag = v[63] ? 64'(-v) : 64'(v);
        q = (mag + 64'(HALF)) >> FRAC;
        return v[63] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
                                                   input logic signed [63:0] lo,
                                                   input logic signed [63:0] hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

endpackage

// ===== design/rlw_radial.sv =====
module rlw_radial (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [17:0]  pos_x,
    input  logic signed [17:0]  pos_y,
    input  rlw_pkg::cfg_t       cfg,
    output logic                out_valid,
    output logic signed [17:0]  out_px,
    output logic signed [17:0]  out_py,
    output logic signed [21:0]  out_ax,
    output logic signed [18:0]  out_dy,
    output logic [16:0]         out_ex,
    output logic signed [49:0]  out_d,
    output logic signed [49:0]  out_de
);
    import rlw_pkg::*;

    localparam int NS = 8;

    logic [NS:1] v_reg;
    logic signed [17:0] px_reg [1:NS];
    logic signed [17:0] py_reg [1:NS];
    logic signed [18:0] dy_reg [1:NS];
    logic [16:0] ex_reg [1:NS];
    logic signed [21:0] ax_reg [2:NS];

    logic signed [36:0] prodx1_reg;
    logic signed [43:0] sqx3_reg;
    logic signed [37:0] sqy3_reg;
    logic [33:0] sqe3_reg;
    logic [30:0] r2_4_reg, r2e_4_reg;
    logic [61:0] r2sq5_reg, r2esq5_reg;
    logic [44:0] r4_6_reg, r4e_6_reg;
    logic signed [63:0] kp7_reg, kpe7_reg;
    logic signed [49:0] d8_reg, de8_reg;

    logic signed [18:0] dx_w, dy_w;
    logic signed [63:0] r2_w, r2e_w, r4_w, r4e_w;

    assign dx_w = 19'(pos_x) - 19'(HALF);
    assign dy_w = 19'(pos_y) - 19'(HALF);
    assign r2_w = clamp64(rnd_frac(64'(sqx3_reg) + 64'(sqy3_reg)), 64'sd0, R2_CAP);
    assign r2e_w = clamp64(rnd_frac($signed(64'(sqe3_reg)) + HALF * HALF), 64'sd0, R2_CAP);
    assign r4_w = clamp64(rnd_frac($signed(64'(r2sq5_reg))), 64'sd0, R4_CAP);
    assign r4e_w = clamp64(rnd_frac($signed(64'(r2esq5_reg))), 64'sd0, R4_CAP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NS-1:1], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg[1] <= pos_x;
            py_reg[1] <= pos_y;
            dy_reg[1] <= dy_w;
            ex_reg[1] <= 17'(({1'b0, cfg.aspect} + 18'd1) >> 1);
            prodx1_reg <= dx_w * $signed({1'b0, cfg.aspect});
            for (int s = 2; s <= NS; s++) begin
                px_reg[s] <= px_reg[s-1];
                py_reg[s] <= py_reg[s-1];
                dy_reg[s] <= dy_reg[s-1];
                ex_reg[s] <= ex_reg[s-1];
            end
            ax_reg[2] <= 22'(rnd_frac(64'(prodx1_reg)));
            for (int s = 3; s <= NS; s++) begin
                ax_reg[s] <= ax_reg[s-1];
            end
            sqx3_reg <= ax_reg[2] * ax_reg[2];
            sqy3_reg <= dy_reg[2] * dy_reg[2];
            sqe3_reg <= ex_reg[2] * ex_reg[2];
            r2_4_reg <= 31'(r2_w);
            r2e_4_reg <= 31'(r2e_w);
            r2sq5_reg <= r2_4_reg * r2_4_reg;
            r2esq5_reg <= r2e_4_reg * r2e_4_reg;
            r4_6_reg <= 45'(r4_w);
            r4e_6_reg <= 45'(r4e_w);
            kp7_reg <= cfg.k4 * $signed({1'b0, r4_6_reg});
            kpe7_reg <= cfg.k4 * $signed({1'b0, r4e_6_reg});
            d8_reg <= 50'(ONE + rnd_frac(kp7_reg));
            de8_reg <= 50'(ONE + rnd_frac(kpe7_reg));
        end
    end

    assign out_valid = v_reg[NS];
    assign out_px = px_reg[NS];
    assign out_py = py_reg[NS];
    assign out_ax = ax_reg[NS];
    assign out_dy = dy_reg[NS];
    assign out_ex = ex_reg[NS];
    assign out_d = d8_reg;
    assign out_de = de8_reg;

endmodule

// ===== design/rlw_div.sv =====
module rlw_div #(
    parameter int LANES = 2,
    parameter int NW = 36,
    parameter int DW = 49,
    parameter int QW = 36,
    parameter int SW = 37
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [NW-1:0]  num [LANES],
    input  logic [DW-1:0]         den [LANES],
    input  logic [SW-1:0]         in_side,
    output logic                  out_valid,
    output logic signed [QW:0]    quo [LANES],
    output logic [SW-1:0]         out_side
);
    // Rounded signed division by a positive divisor, one quotient bit per stage.
    localparam int XW = ((NW > DW) ? NW : DW) + 1;

    logic [QW:0] v_reg;
    logic [SW-1:0] side_reg [QW+1];
    logic [DW-1:0] rem_reg [QW+1][LANES];
    logic [QW-1:0] xq_reg [QW+1][LANES];
    logic [DW-1:0] den_reg [QW+1][LANES];
    logic neg_reg [QW+1][LANES];

    logic [NW-1:0] mag_w [LANES];
    logic [XW-1:0] x_w [LANES];
    logic [DW:0] cat_w [QW][LANES];
    logic [DW:0] diff_w [QW][LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            mag_w[l] = num[l][NW-1] ? NW'(-num[l]) : NW'(num[l]);
            x_w[l] = XW'(mag_w[l]) + XW'(den[l] >> 1);
        end
        for (int s = 0; s < QW; s++) begin
            for (int l = 0; l < LANES; l++) begin
                cat_w[s][l] = {rem_reg[s][l], xq_reg[s][l][QW-1]};
                diff_w[s][l] = cat_w[s][l] - {1'b0, den_reg[s][l]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[QW-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            for (int l = 0; l < LANES; l++) begin
                rem_reg[0][l] <= DW'(x_w[l] >> QW);
                xq_reg[0][l] <= x_w[l][QW-1:0];
                den_reg[0][l] <= den[l];
                neg_reg[0][l] <= num[l][NW-1];
            end
            for (int s = 0; s < QW; s++) begin
                side_reg[s+1] <= side_reg[s];
                for (int l = 0; l < LANES; l++) begin
                    den_reg[s+1][l] <= den_reg[s][l];
                    neg_reg[s+1][l] <= neg_reg[s][l];
                    if (!diff_w[s][l][DW]) begin
                        rem_reg[s+1][l] <= diff_w[s][l][DW-1:0];
                        xq_reg[s+1][l] <= {xq_reg[s][l][QW-2:0], 1'b1};
                    end else begin
                        rem_reg[s+1][l] <= cat_w[s][l][DW-1:0];
                        xq_reg[s+1][l] <= {xq_reg[s][l][QW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            quo[l] = neg_reg[QW][l] ? -$signed({1'b0, xq_reg[QW][l]})
                                    : $signed({1'b0, xq_reg[QW][l]});
        end
    end

    assign out_valid = v_reg[QW];
    assign out_side = side_reg[QW];

endmodule

// ===== design/radial_lens_distortion_warp.sv =====
// Radial lens-distortion warp: each word on the input stream is one UV point in
// signed Q4.14, and each word on the output stream is the warped point, with a
// saturated flag (a coordinate was clamped to the Q4.14 range) and an invalid flag
// (a denominator was not positive, so the point went through unchanged). When
// distortion is disabled or the camera is orthographic, points pass through with
// both flags clear. The block takes one point per clock while s_tready is high
// and returns results in order: eight stages form the radius terms and the
// denominators, a 37-stage pipelined divider scales the offsets, two stages
// apply the inverse aspect and the edge magnification, a 41-stage divider
// applies that magnification, and a final register drives the output. A two-word
// output buffer keeps the input side open while the consumer stalls, so input
// backpressure only appears once the buffer holds two words. Configuration is
// written through the cfg port and must only change while no point is in flight.
module radial_lens_distortion_warp (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // [17:0] pos_x, [35:18] pos_y, [39:36] zero
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,   // [17:0] out_x, [35:18] out_y, [39:36] zero
    output logic [1:0]   m_tuser,   // [0] saturated, [1] invalid
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [17:0]  cfg_data
);
    import rlw_pkg::*;

    cfg_t cfg_reg;
    logic cfg_ready_reg;
    logic in_ready_reg;
    logic en;

    // Configuration registers. Writes to unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable <= 1'b1;
            cfg_reg.persp <= 1'b1;
            cfg_reg.k4 <= '0;
            cfg_reg.aspect <= 17'd29127;
            cfg_reg.inv_aspect <= 17'd9216;
            cfg_ready_reg <= 1'b0;
        end else begin
            cfg_ready_reg <= 1'b1;
            if (cfg_valid && cfg_ready_reg) begin
                case (cfg_index)
                    REG_ENABLE: cfg_reg.enable <= cfg_data[0];
                    REG_PERSP: cfg_reg.persp <= cfg_data[0];
                    REG_K4: cfg_reg.k4 <= $signed(cfg_data);
                    REG_ASPECT: cfg_reg.aspect <= cfg_data[16:0];
                    REG_INV_ASPECT: cfg_reg.inv_aspect <= cfg_data[16:0];
                    default: ;
                endcase
            end
        end
    end

    assign cfg_ready = cfg_ready_reg;

    // The whole pipeline moves whenever the output buffer has room for one more word.
    assign en = in_ready_reg;
    assign s_tready = in_ready_reg;

    // Front end: aspect scaling, r^2, r^4 and the denominators for the point and
    // for the edge reference point.
    logic f_valid;
    logic signed [17:0] f_px, f_py;
    logic signed [21:0] f_ax;
    logic signed [18:0] f_dy;
    logic [16:0] f_ex;
    logic signed [49:0] f_d, f_de;

    rlw_radial u_radial (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid && in_ready_reg),
        .pos_x     ($signed(s_tdata[17:0])),
        .pos_y     ($signed(s_tdata[35:18])),
        .cfg       (cfg_reg),
        .out_valid (f_valid),
        .out_px    (f_px),
        .out_py    (f_py),
        .out_ax    (f_ax),
        .out_dy    (f_dy),
        .out_ex    (f_ex),
        .out_d     (f_d),
        .out_de    (f_de)
    );

    // First division: offsets and the edge offset over their denominators.
    logic signed [35:0] na_w [3];
    logic [48:0] da_w [3];
    logic bad_w;
    logic a_valid;
    logic signed [36:0] qa_w [3];
    logic [36:0] a_side;

    assign na_w[0] = $signed({f_ax, 14'd0});
    assign na_w[1] = 36'($signed({f_dy, 14'd0}));
    assign na_w[2] = $signed(36'({f_ex, 14'd0}));
    assign da_w[0] = f_d[48:0];
    assign da_w[1] = f_d[48:0];
    assign da_w[2] = f_de[48:0];
    assign bad_w = (f_d <= 50'sd0) || (f_de <= 50'sd0);

    rlw_div #(.LANES(3), .NW(36), .DW(49), .QW(36), .SW(37)) u_div_a (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .num       (na_w),
        .den       (da_w),
        .in_side   ({bad_w, f_py, f_px}),
        .out_valid (a_valid),
        .quo       (qa_w),
        .out_side  (a_side)
    );

    // Inverse aspect on x and on the edge offset, then the magnification divisor.
    logic [1:0] b_v_reg;
    logic [36:0] b1_side_reg, b2_side_reg;
    logic signed [54:0] pxa_reg, pea_reg;
    logic signed [36:0] qdy_reg;
    logic signed [38:0] ux_reg, uy_reg;
    logic [34:0] m_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_v_reg <= '0;
        end else if (en) begin
            b_v_reg <= {b_v_reg[0], a_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b1_side_reg <= a_side;
            pxa_reg <= qa_w[0] * $signed({1'b0, cfg_reg.inv_aspect});
            pea_reg <= qa_w[2] * $signed({1'b0, cfg_reg.inv_aspect});
            qdy_reg <= qa_w[1];
            b2_side_reg <= b1_side_reg;
            ux_reg <= 39'(clamp64(rnd_frac(64'(pxa_reg)), -U_CAP, U_CAP));
            uy_reg <= 39'(clamp64(64'(qdy_reg), -U_CAP, U_CAP));
            m_reg <= 35'(rnd_frac(64'(pea_reg)) + HALF);
        end
    end

    // Second division: offsets over the edge magnification, rounded.
    logic signed [52:0] nb_w [2];
    logic [34:0] db_w [2];
    logic c_valid;
    logic signed [40:0] qb_w [2];
    logic [36:0] c_side;

    assign nb_w[0] = $signed({ux_reg, 14'd0});
    assign nb_w[1] = $signed({uy_reg, 14'd0});
    assign db_w[0] = m_reg;
    assign db_w[1] = m_reg;

    rlw_div #(.LANES(2), .NW(53), .DW(35), .QW(40), .SW(37)) u_div_b (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (b_v_reg[1]),
        .num       (nb_w),
        .den       (db_w),
        .in_side   (b2_side_reg),
        .out_valid (c_valid),
        .quo       (qb_w),
        .out_side  (c_side)
    );

    // Recentre, clamp to Q4.14 and pick between warped and unchanged point.
    logic signed [41:0] rx_w, ry_w;
    logic sat_x_w, sat_y_w;
    logic signed [17:0] cx_w, cy_w;
    logic [39:0] res_data_w;
    logic [1:0] res_user_w;

    assign rx_w = 42'(qb_w[0]) + 42'(HALF);
    assign ry_w = 42'(qb_w[1]) + 42'(HALF);
    assign sat_x_w = (rx_w > 42'(OUT_MAX)) || (rx_w < 42'(OUT_MIN));
    assign sat_y_w = (ry_w > 42'(OUT_MAX)) || (ry_w < 42'(OUT_MIN));
    assign cx_w = 18'(clamp64(64'(rx_w), OUT_MIN, OUT_MAX));
    assign cy_w = 18'(clamp64(64'(ry_w), OUT_MIN, OUT_MAX));

    always_comb begin
        if (!(cfg_reg.enable && cfg_reg.persp)) begin
            res_data_w = {4'd0, c_side[35:0]};
            res_user_w = 2'b00;
        end else if (c_side[36]) begin
            res_data_w = {4'd0, c_side[35:0]};
            res_user_w = 2'b10;
        end else begin
            res_data_w = {4'd0, cy_w, cx_w};
            res_user_w = {1'b0, sat_x_w || sat_y_w};
        end
    end

    // Output register with one skid word behind it.
    logic out_valid_reg, skid_valid_reg;
    logic [39:0] out_data_reg, skid_data_reg;
    logic [1:0] out_user_reg, skid_user_reg;
    logic out_free_w, push_w;
    logic skid_valid_next;

    assign out_free_w = !out_valid_reg || m_tready;
    assign push_w = en && c_valid;

    always_comb begin
        if (out_free_w) begin
            skid_valid_next = 1'b0;
        end else begin
            skid_valid_next = skid_valid_reg || push_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
            in_ready_reg <= 1'b0;
        end else begin
            skid_valid_reg <= skid_valid_next;
            in_ready_reg <= !skid_valid_next;
            if (out_free_w) begin
                out_valid_reg <= skid_valid_reg || push_w;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free_w) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end else begin
                out_data_reg <= res_data_w;
                out_user_reg <= res_user_w;
            end
        end else if (push_w) begin
            skid_data_reg <= res_data_w;
            skid_user_reg <= res_user_w;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;
    assign m_tuser = out_user_reg;

endmodule

// ===== design/rlw_checker.sv =====
module rlw_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [39:0]  m_tdata,
    input logic [1:0]   m_tuser
);
    // Reset empties the output side.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output word present after reset");

    // A held word keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output word changed");

    // A point that went through on a bad denominator is never also clamped.
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("saturated and invalid both set");

    // Input backpressure only happens while the output side holds a word.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[39:36] == 4'd0)
        else $error("output padding bits not zero");

endmodule

bind radial_lens_distortion_warp rlw_checker u_rlw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
